// ===== src/mtr_pkg.sv =====
// ----------------------------------------------------------------------------
// mtr_pkg
// Shared types, constants and helpers of the media timestamp resync block.
// ----------------------------------------------------------------------------
package mtr_pkg;

  localparam int MAX_TRACKS = 8;
  localparam int TRK_AW     = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

  localparam int TS_W   = 24;
  localparam int SECS_W = 12;
  localparam int FRM_W  = 10;
  localparam int THR_W  = TS_W + SECS_W;
  localparam int Q_W    = 15;               // timescale / 1000 fits here
  localparam int CFG_AW = 5;

  localparam int        MS_DIV   = 1000;
  localparam int        RECIP_SH = 34;
  localparam logic [24:0] RECIP  = 25'((64'd1 << RECIP_SH) / MS_DIV);
  localparam int        RAM_W    = 192;      // correction, last pts, last out dts

  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

  localparam logic [2:0] REG_TIMESCALE = 3'd0;
  localparam logic [2:0] REG_JUMP_LOG  = 3'd1;
  localparam logic [2:0] REG_JUMP_RSY  = 3'd2;
  localparam logic [2:0] REG_FORCED    = 3'd3;
  localparam logic [2:0] REG_BACK      = 3'd4;
  localparam logic [2:0] REG_FWD       = 3'd5;
  localparam logic [2:0] REG_REUSE     = 3'd6;

  typedef enum logic [2:0] {
    CAUSE_NONE   = 3'd0,
    CAUSE_FORCED = 3'd1,
    CAUSE_FIRST  = 3'd2,
    CAUSE_BACK   = 3'd3,
    CAUSE_FWD    = 3'd4,
    CAUSE_JUMP   = 3'd5
  } cause_t;

  typedef enum logic [1:0] {
    K_FRAME,
    K_RESET,
    K_NONE
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MUL, S_QFIX, S_DEC1, S_DEC2, S_RS1, S_RS2,
    S_RS3, S_DIV, S_RS4, S_CMP, S_SEL, S_WB
  } state_t;

  function automatic logic s_lt(input logic [63:0] a, input logic [63:0] b);
    return (a ^ SIGN64) < (b ^ SIGN64);
  endfunction

  function automatic logic [63:0] u_abs(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

// ===== src/mtr_ram.sv =====
// ----------------------------------------------------------------------------
// mtr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/media_timestamp_resync_core.sv =====
// ----------------------------------------------------------------------------
// media_timestamp_resync_core
// Per-track timestamp corrector with drift and jump driven resync.
// ----------------------------------------------------------------------------
// Input transactions carry one frame (cmd 0) or a track reset (cmd 1) for
// the track in in_track_sel. Each input transaction yields exactly one
// output transaction with the corrected dts, split flag, sync cause and the
// track correction in effect afterwards.
// One item is worked at a time. A frame without resync runs through one RAM
// read, six steps of the shared threshold multiplier, quotient fix-up, two
// decision steps and write-back. A resync adds clamp, offset, divider setup,
// the one-bit-per-cycle wrap-alignment divider, correction, compare and
// select steps; the divider is skipped when timescale is below 1000 and no
// alignment is applied. A track reset passes only the read step and
// write-back. in_ready returns in the cycle the result is loaded.
// Per-track correction, last pts and last output dts live in one RAM that
// is read at acceptance and written back at the end of each frame.
// Reset clears valid bits, countdowns, channel correction and loads the
// default register values; no clearing pass is needed.
// A stalled receiver holds the finished result in the output register; the
// next input transaction is still accepted and waits in write-back.
// ----------------------------------------------------------------------------
module media_timestamp_resync_core
  import mtr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [2:0]          in_track_sel,
  input  logic signed [63:0]  in_frame_dts,
  input  logic signed [31:0]  in_pts_delay,
  input  logic                in_is_video,
  input  logic                in_is_key,
  input  logic signed [63:0]  in_capture_time,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [63:0]  out_dts,
  output logic                out_split_flag,
  output logic [2:0]          out_sync_cause,
  output logic signed [63:0]  out_applied_correction,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  // configuration
  logic [TS_W-1:0]   ts_r;
  logic [SECS_W-1:0] jlog_r, jrsy_r, back_r, fwd_r, reuse_r;
  logic [FRM_W-1:0]  fsf_r;

  state_t state_r, state_nxt;
  kind_t  kind_r;

  logic [TRK_AW-1:0] trk_r;
  logic [63:0] dts_r, pts_r, created_r;
  logic [31:0] delay_r;
  logic        video_r, key_r;

  logic [63:0] chan_r;
  logic [FRM_W-1:0] cd_r [MAX_TRACKS];
  logic [MAX_TRACKS-1:0] corr_vld_r, lpv_r, lov_r;

  logic [63:0] corr_r, prev_pts_r, last_out_r;
  logic [2:0]  idx_r;
  logic [Q_W-1:0] q0_r, q_r;
  logic [THR_W-1:0] thr_log_r, thr_rsy_r, thr_bk_r, thr_fw_r, thr_ru_r;
  logic [63:0] cur_r, lo_r, hi_r, tc_r, diff_r, floor_r;
  logic [63:0] n_r, cc2_r, absd_r, corr_new_r;
  logic [31:0] dvd_r;
  logic [Q_W:0] rem_r;
  logic [4:0]  cnt_r;
  logic        neg_r, clamp_r, cclt_r, split_r;
  logic [FRM_W-1:0] frames_r;
  cause_t      cause_r;

  logic out_valid_r, out_split_r;
  logic [63:0] out_dts_r, out_corr_r;
  cause_t out_cause_r;

  logic [RAM_W-1:0] ram_rd, ram_wd;
  logic ram_we;
  logic [TRK_AW-1:0] acc_trk;
  logic acc, acc_oor, out_free;
  logic [63:0] wb_out_dts;

  // multiplier
  logic [24:0] mul_a;
  logic [48:0] mul_prod;

  // decision
  cause_t dec_cause;
  logic [63:0] dec_floor;
  logic [FRM_W-1:0] dec_frames;
  logic dec_split, dec_rs;

  logic [Q_W:0] rem_sh;
  logic [24:0]  q0_rem;

  assign acc      = in_valid && in_ready;
  assign acc_trk  = TRK_AW'(in_track_sel);
  assign acc_oor  = int'(in_track_sel) >= MAX_TRACKS;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  assign ram_we     = (state_r == S_WB) && out_free && (kind_r == K_FRAME);
  assign wb_out_dts = dts_r + corr_new_r;
  assign ram_wd     = {corr_new_r, pts_r, wb_out_dts};

  mtr_ram #(.WIDTH(RAM_W), .DEPTH(MAX_TRACKS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (trk_r),
    .wdata (ram_wd),
    .raddr (acc_trk),
    .rdata (ram_rd)
  );

  always_comb begin
    case (idx_r)
      3'd0:    mul_a = RECIP;
      3'd1:    mul_a = 25'(jlog_r);
      3'd2:    mul_a = 25'(jrsy_r);
      3'd3:    mul_a = 25'(back_r);
      3'd4:    mul_a = 25'(fwd_r);
      default: mul_a = 25'(reuse_r);
    endcase
  end
  assign mul_prod = 49'(mul_a) * 49'(ts_r);
  assign q0_rem   = 25'(ts_r) - 25'(q0_r) * 25'(MS_DIV);
  assign rem_sh   = {rem_r[Q_W-1:0], dvd_r[5'd31 - cnt_r]};

  always_comb begin
    dec_cause  = CAUSE_NONE;
    dec_floor  = SIGN64;
    dec_frames = '0;
    dec_split  = 1'b0;
    if (video_r && !key_r) begin
      if (lpv_r[trk_r] && diff_r > 64'(thr_log_r) && diff_r > 64'(thr_rsy_r)) begin
        dec_cause = CAUSE_JUMP;
      end
      dec_floor  = floor_r;
      dec_frames = fsf_r;
    end else begin
      if (cd_r[trk_r] == FRM_W'(1)) begin
        dec_cause = CAUSE_FORCED;
      end else if (!lpv_r[trk_r]) begin
        dec_cause = CAUSE_FIRST;
      end else if (s_lt(cur_r, lo_r)) begin
        dec_cause = CAUSE_BACK;
      end else if (s_lt(hi_r, cur_r)) begin
        dec_cause = CAUSE_FWD;
      end
      dec_split  = (dec_cause != CAUSE_NONE);
      dec_frames = (dec_cause == CAUSE_BACK || dec_cause == CAUSE_FWD) ? fsf_r : '0;
    end
    dec_rs = (dec_cause != CAUSE_NONE);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = acc_oor ? S_WB : S_RD;
      S_RD:    state_nxt = (kind_r == K_FRAME) ? S_MUL : S_WB;
      S_MUL:   if (idx_r == 3'd5) state_nxt = S_QFIX;
      S_QFIX:  state_nxt = S_DEC1;
      S_DEC1:  state_nxt = S_DEC2;
      S_DEC2:  state_nxt = dec_rs ? S_RS1 : S_WB;
      S_RS1:   state_nxt = S_RS2;
      S_RS2:   state_nxt = S_RS3;
      S_RS3:   state_nxt = (q_r == '0) ? S_RS4 : S_DIV;
      S_DIV:   if (cnt_r == 5'd31) state_nxt = S_RS4;
      S_RS4:   state_nxt = S_CMP;
      S_CMP:   state_nxt = S_SEL;
      S_SEL:   state_nxt = S_WB;
      S_WB:    if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration port
  assign cfg_pready = 1'b1;
  always_comb begin
    case (cfg_paddr[4:2])
      REG_TIMESCALE: cfg_prdata = 32'(ts_r);
      REG_JUMP_LOG:  cfg_prdata = 32'(jlog_r);
      REG_JUMP_RSY:  cfg_prdata = 32'(jrsy_r);
      REG_FORCED:    cfg_prdata = 32'(fsf_r);
      REG_BACK:      cfg_prdata = 32'(back_r);
      REG_FWD:       cfg_prdata = 32'(fwd_r);
      REG_REUSE:     cfg_prdata = 32'(reuse_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r    <= TS_W'(90000);
      jlog_r  <= SECS_W'(10);
      jrsy_r  <= SECS_W'(100);
      fsf_r   <= FRM_W'(10);
      back_r  <= SECS_W'(20);
      fwd_r   <= SECS_W'(20);
      reuse_r <= SECS_W'(10);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr[4:2])
        REG_TIMESCALE: ts_r    <= cfg_pwdata[TS_W-1:0];
        REG_JUMP_LOG:  jlog_r  <= cfg_pwdata[SECS_W-1:0];
        REG_JUMP_RSY:  jrsy_r  <= cfg_pwdata[SECS_W-1:0];
        REG_FORCED:    fsf_r   <= cfg_pwdata[FRM_W-1:0];
        REG_BACK:      back_r  <= cfg_pwdata[SECS_W-1:0];
        REG_FWD:       fwd_r   <= cfg_pwdata[SECS_W-1:0];
        REG_REUSE:     reuse_r <= cfg_pwdata[SECS_W-1:0];
        default: ;
      endcase
    end
  end

  // per-track control state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r      <= '0;
      corr_vld_r  <= '0;
      lpv_r       <= '0;
      lov_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_TRACKS; k++) cd_r[k] <= '0;
    end else begin
      if (state_r == S_WB && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (acc && !acc_oor) begin
        if (in_cmd) begin
          lpv_r[acc_trk] <= 1'b0;
          lov_r[acc_trk] <= 1'b0;
          cd_r[acc_trk]  <= '0;
        end else if (cd_r[acc_trk] > FRM_W'(1)) begin
          cd_r[acc_trk] <= cd_r[acc_trk] - FRM_W'(1);
        end
      end
      if (state_r == S_SEL) begin
        if (!(absd_r < 64'(thr_ru_r) && !cclt_r)) begin
          chan_r <= tc_r;
          // arm a forced resync on every other track
          if ((clamp_r || cd_r[trk_r] == '0) && frames_r != '0) begin
            for (int k = 0; k < MAX_TRACKS; k++) begin
              if (TRK_AW'(k) != trk_r) cd_r[k] <= frames_r;
            end
          end
        end
        cd_r[trk_r] <= '0;
      end
      if (state_r == S_WB && out_free) begin
        if (kind_r == K_FRAME) begin
          corr_vld_r[trk_r] <= 1'b1;
          lpv_r[trk_r]      <= 1'b1;
          lov_r[trk_r]      <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        trk_r     <= acc_trk;
        kind_r    <= acc_oor ? K_NONE : (in_cmd ? K_RESET : K_FRAME);
        dts_r     <= in_frame_dts;
        delay_r   <= in_pts_delay;
        video_r   <= in_is_video;
        key_r     <= in_is_key;
        created_r <= in_capture_time;
        idx_r     <= '0;
      end
      S_RD: begin
        corr_r     <= corr_vld_r[trk_r] ? ram_rd[191:128] : 64'd0;
        prev_pts_r <= ram_rd[127:64];
        last_out_r <= ram_rd[63:0];
        pts_r      <= video_r ? dts_r + {{32{delay_r[31]}}, delay_r} : dts_r;
      end
      S_MUL: begin
        case (idx_r)
          3'd0:    q0_r      <= mul_prod[RECIP_SH +: Q_W];
          3'd1:    thr_log_r <= mul_prod[THR_W-1:0];
          3'd2:    thr_rsy_r <= mul_prod[THR_W-1:0];
          3'd3:    thr_bk_r  <= mul_prod[THR_W-1:0];
          3'd4:    thr_fw_r  <= mul_prod[THR_W-1:0];
          default: thr_ru_r  <= mul_prod[THR_W-1:0];
        endcase
        idx_r <= idx_r + 3'd1;
      end
      S_QFIX: begin
        q_r <= (q0_rem >= 25'(MS_DIV)) ? q0_r + Q_W'(1) : q0_r;
      end
      S_DEC1: begin
        cur_r   <= pts_r + corr_r;
        lo_r    <= created_r - 64'(thr_bk_r);
        hi_r    <= created_r + 64'(thr_fw_r);
        tc_r    <= created_r - pts_r;
        diff_r  <= s_lt(pts_r, prev_pts_r) ? prev_pts_r - pts_r : pts_r - prev_pts_r;
        floor_r <= lov_r[trk_r] ? last_out_r + 64'd1 - dts_r : SIGN64;
      end
      S_DEC2: begin
        cause_r    <= dec_cause;
        split_r    <= dec_split;
        frames_r   <= dec_frames;
        floor_r    <= dec_floor;
        corr_new_r <= corr_r;
      end
      S_RS1: begin
        // clamp so output dts keeps rising
        clamp_r <= s_lt(tc_r, floor_r);
        if (s_lt(tc_r, floor_r)) tc_r <= floor_r;
      end
      S_RS2: begin
        // add half the wrap value before rounding
        n_r <= tc_r - chan_r + {18'd0, q_r, 31'd0};
      end
      S_RS3: begin
        neg_r <= n_r[63];
        dvd_r <= (q_r == '0) ? 32'd0 : 32'(u_abs(n_r) >> 32);
        rem_r <= '0;
        cnt_r <= '0;
      end
      S_DIV: begin
        rem_r <= (rem_sh >= {1'b0, q_r}) ? rem_sh - {1'b0, q_r} : rem_sh;
        cnt_r <= cnt_r + 5'd1;
      end
      S_RS4: begin
        cc2_r <= neg_r ? chan_r - {dvd_r - 32'(rem_r), 32'd0}
                       : chan_r + {dvd_r - 32'(rem_r), 32'd0};
      end
      S_CMP: begin
        absd_r <= u_abs(cc2_r - tc_r);
        cclt_r <= s_lt(cc2_r, floor_r);
      end
      S_SEL: begin
        corr_new_r <= (absd_r < 64'(thr_ru_r) && !cclt_r) ? cc2_r : tc_r;
      end
      S_WB: begin
        if (out_free) begin
          case (kind_r)
            K_FRAME: begin
              out_dts_r   <= wb_out_dts;
              out_split_r <= split_r;
              out_cause_r <= cause_r;
              out_corr_r  <= corr_new_r;
            end
            K_RESET: begin
              out_dts_r   <= '0;
              out_split_r <= 1'b0;
              out_cause_r <= CAUSE_NONE;
              out_corr_r  <= corr_r;
            end
            default: begin
              out_dts_r   <= '0;
              out_split_r <= 1'b0;
              out_cause_r <= CAUSE_NONE;
              out_corr_r  <= '0;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  assign out_valid              = out_valid_r;
  assign out_dts                = out_dts_r;
  assign out_split_flag         = out_split_r;
  assign out_sync_cause         = out_cause_r;
  assign out_applied_correction = out_corr_r;

endmodule

// ===== src/mtr_checker.sv =====
// ----------------------------------------------------------------------------
// mtr_sva
// Port-level checks of the media timestamp resync block.
// ----------------------------------------------------------------------------
module mtr_sva
  import mtr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_dts,
  input logic        out_split_flag,
  input logic [2:0]  out_sync_cause
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dts))
    else $error("stalled result changed");

  a_split_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_split_flag == (out_sync_cause == CAUSE_FORCED ||
      out_sync_cause == CAUSE_FIRST || out_sync_cause == CAUSE_BACK ||
      out_sync_cause == CAUSE_FWD))
    else $error("split flag disagrees with sync cause");

  a_cause_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sync_cause <= CAUSE_JUMP)
    else $error("sync cause out of range");

  // one transaction in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while busy");

endmodule

bind media_timestamp_resync_core mtr_sva u_mtr_sva (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_dts        (out_dts),
  .out_split_flag (out_split_flag),
  .out_sync_cause (out_sync_cause)
);
